FILE: design/rlo_pkg.sv
// Shared widths, register map, reset values and types for the rear-leg odometry unit.
`default_nettype none

package rlo_pkg;

    localparam int ANGLE_W    = 16;
    localparam int LEN_W      = 16;
    localparam int SINE_W     = 16;
    localparam int SINE_MAG_W = 15;
    localparam int OFFSET_W   = 18;
    localparam int POS_W      = 32;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int SINE_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        REG_START_X       = 2'd0,
        REG_BASE_OFFSET_X = 2'd1,
        REG_THIGH_LENGTH  = 2'd2,
        REG_SHANK_LENGTH  = 2'd3
    } t_reg_idx;

    localparam logic signed [POS_W-1:0] START_X_RST       = '0;
    localparam logic [LEN_W-1:0]        BASE_OFFSET_X_RST = 16'd16089;
    localparam logic [LEN_W-1:0]        THIGH_LENGTH_RST  = 16'd15073;
    localparam logic [LEN_W-1:0]        SHANK_LENGTH_RST  = 16'd15073;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic [LEN_W-1:0]        base_offset_x;
        logic [LEN_W-1:0]        thigh_length;
        logic [LEN_W-1:0]        shank_length;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/rlo_cfg_regs.sv
// APB-style configuration registers: body start position and leg geometry.
`default_nettype none

module rlo_cfg_regs
    import rlo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x       <= START_X_RST;
            r_cfg.base_offset_x <= BASE_OFFSET_X_RST;
            r_cfg.thigh_length  <= THIGH_LENGTH_RST;
            r_cfg.shank_length  <= SHANK_LENGTH_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_START_X:       r_cfg.start_x       <= $signed(pwdata);
                REG_BASE_OFFSET_X: r_cfg.base_offset_x <= pwdata[LEN_W-1:0];
                REG_THIGH_LENGTH:  r_cfg.thigh_length  <= pwdata[LEN_W-1:0];
                REG_SHANK_LENGTH:  r_cfg.shank_length  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_START_X:       prdata = r_cfg.start_x;
            REG_BASE_OFFSET_X: prdata = CFG_DATA_W'(r_cfg.base_offset_x);
            REG_THIGH_LENGTH:  prdata = CFG_DATA_W'(r_cfg.thigh_length);
            REG_SHANK_LENGTH:  prdata = CFG_DATA_W'(r_cfg.shank_length);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/rlo_sine_rom.sv
// Quarter-wave sine table with two registered read ports, angle in, signed Q1.15 out.
`default_nettype none

module rlo_sine_rom
    import rlo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [ANGLE_W-1:0]       i_angle_a,
    input  wire logic [ANGLE_W-1:0]       i_angle_b,
    output logic signed [SINE_W-1:0]      o_sine_a,
    output logic signed [SINE_W-1:0]      o_sine_b
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PHASE_W = ANGLE_W - 1;
    localparam int PROD_W  = PHASE_W + IDX_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [0:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef logic [SINE_MAG_W-1:0] t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 0; k < 6; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k[0] == 1'b0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            q = (sum + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tab[i] = q[SINE_MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic logic [IDX_W-1:0] angle_index(input logic [ANGLE_W-1:0] a);
        logic [PHASE_W-1:0] p;
        logic [PROD_W-1:0]  prod;
        p = PHASE_W'(a[ANGLE_W-3:0]);
        if (a[ANGLE_W-2]) begin
            p = PHASE_W'(1 << (ANGLE_W - 2)) - p;
        end
        prod = PROD_W'(p) * PROD_W'(SINE_TABLE_DEPTH);
        return prod[ANGLE_W-2 +: IDX_W];
    endfunction

    logic [IDX_W-1:0]      idx_a;
    logic [IDX_W-1:0]      idx_b;
    logic [SINE_MAG_W-1:0] mag_a;
    logic [SINE_MAG_W-1:0] mag_b;

    assign idx_a = angle_index(i_angle_a);
    assign idx_b = angle_index(i_angle_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            mag_a <= SINE_ROM[idx_a];
            mag_b <= SINE_ROM[idx_b];
        end
    end

    logic r_neg_a;
    logic r_neg_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_angle_a[ANGLE_W-1];
            r_neg_b <= i_angle_b[ANGLE_W-1];
        end
    end

    assign o_sine_a = r_neg_a ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
    assign o_sine_b = r_neg_b ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});

endmodule

`default_nettype wire

FILE: design/rear_leg_odometry_unit.sv
// Top level: rear-leg forward kinematics and stance-leg body x odometry.
//
//   port group        dir  handshake           content
//   joint word        in   i_valid / o_ready   four joint angles, right contact
//   odometry word     out  o_valid / i_ready   body x, foot offset, stance leg
//   configuration     in   psel/penable/pwrite start x, base offset, link lengths
//
// One word per cycle sustained while i_ready stays high; each word passes one register each
// for angle select, sine table read, multiply, round, travel and body x before o_valid rises.
// Synchronous active-low reset empties the pipeline, zeroes travel and the previous
// offset, arms both legs and restores register defaults.
// Each stage holds while the next one is full and stalled; o_ready stays high while
// any stage ahead of a stalled output is empty.
`default_nettype none

module rear_leg_odometry_unit
    import rlo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [ANGLE_W-1:0]    i_right_thigh_angle,
    input  wire logic [ANGLE_W-1:0]    i_right_knee_angle,
    input  wire logic [ANGLE_W-1:0]    i_left_thigh_angle,
    input  wire logic [ANGLE_W-1:0]    i_left_knee_angle,
    input  wire logic                  i_right_contact,

    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [POS_W-1:0]    o_body_x,
    output logic signed [OFFSET_W-1:0] o_foot_offset,
    output logic                       o_stance_right,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int NSTG  = 6;
    localparam int PROD_W = LEN_W + SINE_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHF_W  = ACC_W - 15;
    localparam int DLT_W  = OFFSET_W + 1;

    localparam logic signed [SHF_W-1:0] OFF_MAX = SHF_W'((1 <<< (OFFSET_W - 1)) - 1);
    localparam logic signed [SHF_W-1:0] OFF_MIN = -SHF_W'(1 <<< (OFFSET_W - 1));
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    t_cfg cfg;

    rlo_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage occupancy and advance
    logic [NSTG:1] r_valid;
    logic [NSTG:1] n_valid;
    logic [NSTG:1] free;

    always_comb begin
        free[NSTG] = !r_valid[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            free[k] = !r_valid[k] || free[k+1];
        end
        n_valid[1] = free[1] ? i_valid : r_valid[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_valid[k] = free[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = free[1];
    assign o_valid = r_valid[NSTG];

    // stage 1: select stance leg angles
    logic [ANGLE_W-1:0] r1_thigh;
    logic [ANGLE_W-1:0] r1_sum;
    logic               r1_right;

    always_ff @(posedge i_clk) begin
        if (free[1]) begin
            r1_right <= i_right_contact;
            if (i_right_contact) begin
                r1_thigh <= i_right_thigh_angle;
                r1_sum   <= i_right_thigh_angle + i_right_knee_angle;
            end else begin
                r1_thigh <= i_left_thigh_angle;
                r1_sum   <= i_left_thigh_angle + i_left_knee_angle;
            end
        end
    end

    // stage 2: sine table read
    logic signed [SINE_W-1:0] s2_sin_thigh;
    logic signed [SINE_W-1:0] s2_sin_sum;
    logic                     r2_right;

    rlo_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .i_clk     (i_clk),
        .i_en      (free[2]),
        .i_angle_a (r1_thigh),
        .i_angle_b (r1_sum),
        .o_sine_a  (s2_sin_thigh),
        .o_sine_b  (s2_sin_sum)
    );

    always_ff @(posedge i_clk) begin
        if (free[2]) begin
            r2_right <= r1_right;
        end
    end

    // stage 3: link length products
    logic signed [PROD_W-1:0] r3_p_thigh;
    logic signed [PROD_W-1:0] r3_p_shank;
    logic                     r3_right;

    always_ff @(posedge i_clk) begin
        if (free[3]) begin
            r3_p_thigh <= PROD_W'($signed({1'b0, cfg.thigh_length}) * s2_sin_thigh);
            r3_p_shank <= PROD_W'($signed({1'b0, cfg.shank_length}) * s2_sin_sum);
            r3_right   <= r2_right;
        end
    end

    // stage 4: sum, round to Q16, saturate
    logic signed [ACC_W-1:0]    s4_acc;
    logic signed [SHF_W-1:0]    s4_shf;
    logic signed [OFFSET_W-1:0] s4_offset;
    logic signed [OFFSET_W-1:0] r4_offset;
    logic                       r4_right;

    always_comb begin
        s4_acc = $signed({(ACC_W-LEN_W-15)'(0), cfg.base_offset_x, 15'b0})
               + ACC_W'(r3_p_thigh) + ACC_W'(r3_p_shank) + ACC_W'(16384);
        s4_shf = s4_acc[ACC_W-1:15];
        if (s4_shf > OFF_MAX) begin
            s4_offset = OFF_MAX[OFFSET_W-1:0];
        end else if (s4_shf < OFF_MIN) begin
            s4_offset = OFF_MIN[OFFSET_W-1:0];
        end else begin
            s4_offset = s4_shf[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[4]) begin
            r4_offset <= s4_offset;
            r4_right  <= r3_right;
        end
    end

    // stage 5: stance tracking and travel accumulation
    logic signed [POS_W-1:0]    r_travel;
    logic signed [OFFSET_W-1:0] r_prev_offset;
    logic                       r_right_armed;
    logic                       r_left_armed;

    logic                       s5_load;
    logic                       s5_rearm;
    logic signed [OFFSET_W-1:0] s5_prev;
    logic signed [DLT_W-1:0]    s5_delta;
    logic signed [POS_W:0]      s5_sum;
    logic signed [POS_W-1:0]    n_travel;

    always_comb begin
        s5_load  = r_valid[4] && free[5];
        s5_rearm = r4_right ? r_right_armed : r_left_armed;
        s5_prev  = s5_rearm ? r4_offset : r_prev_offset;
        s5_delta = DLT_W'(r4_offset) - DLT_W'(s5_prev);
        s5_sum   = (POS_W+1)'(r_travel) + (POS_W+1)'(s5_delta);
        if (s5_sum[POS_W] != s5_sum[POS_W-1]) begin
            n_travel = s5_sum[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            n_travel = s5_sum[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel      <= '0;
            r_prev_offset <= '0;
            r_right_armed <= 1'b1;
            r_left_armed  <= 1'b1;
        end else if (s5_load) begin
            r_travel      <= n_travel;
            r_prev_offset <= r4_offset;
            if (s5_rearm) begin
                r_right_armed <= !r4_right;
                r_left_armed  <= r4_right;
            end
        end
    end

    logic signed [POS_W-1:0]    r5_travel;
    logic signed [OFFSET_W-1:0] r5_offset;
    logic                       r5_right;

    always_ff @(posedge i_clk) begin
        if (free[5]) begin
            r5_travel <= n_travel;
            r5_offset <= r4_offset;
            r5_right  <= r4_right;
        end
    end

    // stage 6: body position output
    logic signed [POS_W:0]   s6_sum;
    logic signed [POS_W-1:0] s6_body;

    always_comb begin
        s6_sum = (POS_W+1)'(cfg.start_x) + (POS_W+1)'(r5_travel);
        if (s6_sum[POS_W] != s6_sum[POS_W-1]) begin
            s6_body = s6_sum[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            s6_body = s6_sum[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[NSTG]) begin
            o_body_x       <= s6_body;
            o_foot_offset  <= r5_offset;
            o_stance_right <= r5_right;
        end
    end

    a_one_leg_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_right_armed || r_left_armed)
        else $error("both legs disarmed");

    a_right_stance_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s5_load && r4_right) |=> (!r_right_armed && r_left_armed))
        else $error("right stance word left right leg armed");

    a_prev_tracks_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s5_load |=> (r_prev_offset == r5_offset))
        else $error("previous offset not taken from the word just accumulated");

    a_travel_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s5_load |=> $stable(r_travel))
        else $error("travel moved without a word");

    a_travel_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s5_load |=> (r5_travel == r_travel))
        else $error("staged travel differs from accumulator");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the rear-leg odometry unit: predicts every word and compares.
`timescale 1ns / 1ps

module tb;
    import rlo_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 64;
    localparam int RANDOM_ROUNDS   = 6;
    localparam int ROUND_WORDS     = 60;
    localparam int BACKPRESS_WORDS = 40;
    localparam int RAMP_UP_PAIRS   = 4;
    localparam int RAMP_DOWN_PAIRS = 4;

    localparam longint POS_MIN    = -(64'sd1 <<< (POS_W - 1));
    localparam longint POS_MAX    = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint OFFSET_MIN = -(64'sd1 <<< (OFFSET_W - 1));
    localparam longint OFFSET_MAX = (64'sd1 <<< (OFFSET_W - 1)) - 1;

    localparam logic [ANGLE_W-1:0] ANGLE_UP   = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANGLE_DOWN = 16'hC000;

    typedef struct packed {
        logic signed [POS_W-1:0]    body_x;
        logic signed [OFFSET_W-1:0] foot_offset;
        logic                       stance_right;
    } t_odo_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [ANGLE_W-1:0]         i_right_thigh_angle;
    logic [ANGLE_W-1:0]         i_right_knee_angle;
    logic [ANGLE_W-1:0]         i_left_thigh_angle;
    logic [ANGLE_W-1:0]         i_left_knee_angle;
    logic                       i_right_contact;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [POS_W-1:0]    o_body_x;
    logic signed [OFFSET_W-1:0] o_foot_offset;
    logic                       o_stance_right;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [CFG_ADDR_W-1:0]      paddr;
    logic [CFG_DATA_W-1:0]      pwdata;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;

    int        sine_rom [0:SINE_DEPTH_DEF];
    int        cfg_start_x;
    int        cfg_base_offset;
    int        cfg_thigh_len;
    int        cfg_shank_len;
    int        travel_q16;
    int        last_offset;
    bit        right_rearm;
    bit        left_rearm;
    t_odo_word odo_expected [$];

    int mismatches    = 0;
    int joints_sent   = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int stall_cycles  = 0;
    bit src_idle_en;
    bit sink_idle_en;
    bit hold_req;

    rear_leg_odometry_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_right_thigh_angle (i_right_thigh_angle),
        .i_right_knee_angle  (i_right_knee_angle),
        .i_left_thigh_angle  (i_left_thigh_angle),
        .i_left_knee_angle   (i_left_knee_angle),
        .i_right_contact     (i_right_contact),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_body_x            (o_body_x),
        .o_foot_offset       (o_foot_offset),
        .o_stance_right      (o_stance_right),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int sine_of(logic [ANGLE_W-1:0] a);
        int phase;
        int v;
        phase = a[13:0];
        if (a[14]) begin
            phase = 16384 - phase;
        end
        v = sine_rom[(phase * SINE_DEPTH_DEF) >> 14];
        return a[15] ? -v : v;
    endfunction

    function automatic int foot_offset_of(logic [ANGLE_W-1:0] thigh, logic [ANGLE_W-1:0] knee);
        logic [ANGLE_W-1:0] tip;
        longint             acc;
        tip = thigh + knee;
        acc = longint'(cfg_base_offset) * 32768
            + longint'(cfg_thigh_len) * sine_of(thigh)
            + longint'(cfg_shank_len) * sine_of(tip);
        return int'(clamp((acc + 16384) >>> 15, OFFSET_MIN, OFFSET_MAX));
    endfunction

    function automatic t_odo_word predict_odometry(input logic [ANGLE_W-1:0] rt, rk, lt, lk,
                                                   input logic right_stance);
        int        offset;
        t_odo_word w;
        if (right_stance) begin
            offset = foot_offset_of(rt, rk);
            if (right_rearm) begin
                right_rearm = 1'b0;
                left_rearm  = 1'b1;
                last_offset = offset;
            end
        end else begin
            offset = foot_offset_of(lt, lk);
            if (left_rearm) begin
                left_rearm  = 1'b0;
                right_rearm = 1'b1;
                last_offset = offset;
            end
        end
        travel_q16 = int'(clamp(longint'(travel_q16) + offset - last_offset, POS_MIN, POS_MAX));
        last_offset = offset;
        w.body_x       = POS_W'(clamp(longint'(cfg_start_x) + travel_q16, POS_MIN, POS_MAX));
        w.foot_offset  = offset[OFFSET_W-1:0];
        w.stance_right = right_stance;
        return w;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return LEN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        if ($urandom_range(0, 3) == 0) begin
            return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 31) - 16);
        end
        return ANGLE_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_joint(input logic [ANGLE_W-1:0] rt, rk, lt, lk, input logic contact);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_right_thigh_angle <= rt;
        i_right_knee_angle  <= rk;
        i_left_thigh_angle  <= lt;
        i_left_knee_angle   <= lk;
        i_right_contact     <= contact;
        do @(posedge i_clk); while (!o_ready);
        odo_expected.push_back(predict_odometry(rt, rk, lt, lk, contact));
        joints_sent++;
    endtask

    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (odo_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_X:       cfg_start_x     = int'(value);
            REG_BASE_OFFSET_X: cfg_base_offset = {16'd0, value[LEN_W-1:0]};
            REG_THIGH_LENGTH:  cfg_thigh_len   = {16'd0, value[LEN_W-1:0]};
            REG_SHANK_LENGTH:  cfg_shank_len   = {16'd0, value[LEN_W-1:0]};
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic test_angle_extremes();
        send_joint(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_joint(16'h4000, 16'h0000, 16'h1234, 16'h4321, 1'b1);
        send_joint(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
        send_joint(16'h8000, 16'h4000, 16'hFFFF, 16'hFFFF, 1'b1);
        send_joint(16'hC000, 16'h8000, 16'h5555, 16'hAAAA, 1'b1);
        send_joint(16'h3FFF, 16'h0001, 16'hAAAA, 16'h5555, 1'b1);
        send_joint(16'h0000, 16'h0000, 16'h4000, 16'hC000, 1'b0);
        send_joint(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b0);
        send_joint(16'h8001, 16'h7FFF, 16'hBFFF, 16'h4001, 1'b0);
        send_joint(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b0);
        send_joint(16'h2000, 16'h1000, 16'h0000, 16'h0000, 1'b1);
        send_joint(16'h0000, 16'h0000, 16'h6000, 16'hA000, 1'b0);
        send_joint(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_register_extremes();
        settle_pipeline();
        write_reg(REG_START_X, 32'h7FFF_FFFF);
        write_reg(REG_BASE_OFFSET_X, 32'd0);
        write_reg(REG_THIGH_LENGTH, 32'd0);
        write_reg(REG_SHANK_LENGTH, 32'd0);
        send_joint(16'h4000, 16'h0000, 16'hC000, 16'h0000, 1'b1);
        send_joint(16'hC000, 16'h0000, 16'h4000, 16'h0000, 1'b0);
        settle_pipeline();
        write_reg(REG_START_X, 32'h8000_0000);
        write_reg(REG_BASE_OFFSET_X, 32'h0000_FFFF);
        write_reg(REG_THIGH_LENGTH, 32'h0000_FFFF);
        write_reg(REG_SHANK_LENGTH, 32'h0000_FFFF);
        send_joint(ANGLE_UP, 16'h0000, ANGLE_DOWN, 16'h0000, 1'b1);
        send_joint(ANGLE_DOWN, 16'h0000, ANGLE_UP, 16'h0000, 1'b1);
        send_joint(ANGLE_DOWN, 16'h0000, ANGLE_UP, 16'h0000, 1'b0);
        send_joint(ANGLE_UP, 16'h0000, ANGLE_DOWN, 16'h0000, 1'b0);
    endtask

    task automatic test_random_gait();
        logic contact;
        int   run;
        contact = 1'b0;
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            settle_pipeline();
            write_reg(REG_START_X, $urandom());
            write_reg(REG_BASE_OFFSET_X, CFG_DATA_W'(random_length()));
            write_reg(REG_THIGH_LENGTH, CFG_DATA_W'(random_length()));
            write_reg(REG_SHANK_LENGTH, CFG_DATA_W'(random_length()));
            src_idle_en  = (r != 3);
            sink_idle_en = (r != 3);
            run = 0;
            for (int n = 0; n < ROUND_WORDS; n++) begin
                if (run == 0) begin
                    contact = $urandom_range(0, 1);
                    run     = $urandom_range(1, 8);
                end
                run--;
                send_joint(random_angle(), random_angle(), random_angle(), random_angle(),
                           contact);
            end
        end
    endtask

    task automatic test_output_backpressure();
        settle_pipeline();
        write_reg(REG_START_X, $urandom());
        write_reg(REG_BASE_OFFSET_X, CFG_DATA_W'(BASE_OFFSET_X_RST));
        write_reg(REG_THIGH_LENGTH, CFG_DATA_W'(THIGH_LENGTH_RST));
        write_reg(REG_SHANK_LENGTH, CFG_DATA_W'(SHANK_LENGTH_RST));
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b1;
        for (int n = 0; n < BACKPRESS_WORDS; n++) begin
            send_joint(random_angle(), random_angle(), random_angle(), random_angle(),
                       1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_travel_limits();
        settle_pipeline();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(REG_START_X, 32'd0);
        write_reg(REG_BASE_OFFSET_X, 32'd0);
        write_reg(REG_THIGH_LENGTH, 32'h0000_FFFF);
        write_reg(REG_SHANK_LENGTH, 32'h0000_FFFF);
        for (int n = 0; n < RAMP_UP_PAIRS; n++) begin
            send_joint(ANGLE_DOWN, 16'h0000, ANGLE_DOWN, 16'h0000, n[0]);
            send_joint(ANGLE_UP, 16'h0000, ANGLE_UP, 16'h0000, n[0]);
        end
        settle_pipeline();
        write_reg(REG_START_X, 32'h7FFF_FFFF);
        for (int n = 0; n < 4; n++) begin
            send_joint(ANGLE_UP, 16'h0000, ANGLE_UP, 16'h0000, n[0]);
        end
        for (int n = 0; n < RAMP_DOWN_PAIRS; n++) begin
            send_joint(ANGLE_UP, 16'h0000, ANGLE_UP, 16'h0000, n[0]);
            send_joint(ANGLE_DOWN, 16'h0000, ANGLE_DOWN, 16'h0000, n[0]);
        end
        settle_pipeline();
        write_reg(REG_START_X, 32'h8000_0000);
        for (int n = 0; n < 4; n++) begin
            send_joint(ANGLE_DOWN, 16'h0000, ANGLE_DOWN, 16'h0000, n[0]);
        end
    endtask

    initial begin : sink_pacing
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_odometry
        t_odo_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (odo_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected word body_x=%0d foot_offset=%0d stance=%0b",
                                        o_body_x, o_foot_offset, o_stance_right));
            end else begin
                want = odo_expected.pop_front();
                if (o_body_x !== want.body_x || o_foot_offset !== want.foot_offset ||
                    o_stance_right !== want.stance_right) begin
                    note_mismatch($sformatf(
                        "word %0d expected body_x=%0d foot_offset=%0d stance=%0b, got %0d %0d %0b",
                        words_checked, want.body_x, want.foot_offset, want.stance_right,
                        o_body_x, o_foot_offset, o_stance_right));
                end
            end
            words_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", stall_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run_tests
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        longint unsigned k;
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_right_thigh_angle <= '0;
        i_right_knee_angle  <= '0;
        i_left_thigh_angle  <= '0;
        i_left_knee_angle   <= '0;
        i_right_contact     <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;

        for (int i = 0; i <= SINE_DEPTH_DEF; i++) begin
            x    = (64'(i) * 64'd1686629713) / 64'(SINE_DEPTH_DEF);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                sum  = k[0] ? sum - term : sum + term;
            end
            q = (sum + 16384) >> 15;
            sine_rom[i] = (q > 32767) ? 32767 : int'(q);
        end

        cfg_start_x     = START_X_RST;
        cfg_base_offset = {16'd0, BASE_OFFSET_X_RST};
        cfg_thigh_len   = {16'd0, THIGH_LENGTH_RST};
        cfg_shank_len   = {16'd0, SHANK_LENGTH_RST};
        travel_q16      = 0;
        last_offset     = 0;
        right_rearm     = 1'b1;
        left_rearm      = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_angle_extremes();
        test_register_extremes();
        test_random_gait();
        test_output_backpressure();
        test_travel_limits();
        settle_pipeline();

        $display("Sent %0d joint words, checked %0d odometry words, %0d register writes",
                 joints_sent, words_checked, reg_writes);
        $display("Covered angle and length extremes, stance changes, random gait, stalls, %s",
                 "output hold-off and body x saturation");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: rear_leg_odometry_unit.f
design/rlo_pkg.sv
design/rlo_cfg_regs.sv
design/rlo_sine_rom.sv
design/rear_leg_odometry_unit.sv
tb/tb.sv
